// ===== rtl/iconv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iconv_pkg: shared constants and types of the 3x3 clamp-edge convolution
// Frame limits, field widths, fixed-point format, register indexes and the
// records that travel between the issue logic and the datapath stages.
// ----------------------------------------------------------------------------
package iconv_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;
	localparam int TAPS       = 3;
	localparam int NTAP       = TAPS * TAPS;
	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 14;
	localparam int COEF_ROW_W = TAPS * COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_ROW_W;
	localparam int PROD_W     = PIX_W + 1 + COEF_W;
	localparam int SUM_W      = PROD_W + 4;
	localparam int NSLOT      = 4;

	localparam logic [DIM_W-1:0]      DIM_RESET      = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]      HEIGHT_RESET   = DIM_W'(MAX_HEIGHT);
	localparam logic [COEF_ROW_W-1:0] COEF_TOP_RESET = '0;
	localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = COEF_ROW_W'(48'h0000_4000_0000);
	localparam logic [COEF_ROW_W-1:0] COEF_BOT_RESET = '0;
	localparam logic [SUM_W-1:0]      ROUND_HALF     = SUM_W'(1) << (COEF_FRAC - 1);
	localparam logic [PIX_W-1:0]      PIX_MAX        = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MID     = 3'd3,
		REG_COEF_BOTTOM  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [NSLOT-1:0] rem;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             up_edge;
		logic             low_edge;
		logic             left_edge;
		logic             end_edge;
		logic             frame_end;
	} job_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
		logic             done;
	} meta_t;

endpackage
`default_nettype wire

// ===== rtl/image_conv3x3_clamp_edge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_conv3x3_clamp_edge: 3x3 convolution with replicated frame border
// Pixels enter in raster order on the in channel (in_valid / in_stall).
// Filtered pixels leave on the out channel (out_valid / out_stall) with
// their column and row, last_of_run on the final word caused by one input
// and frame_done on the final word of the frame. Row y leaves while row
// y+1 enters, one column behind; the last row leaves with the row before.
// An input causes zero to four words. Two line buffers (one RAM each,
// registered read) and a 3x3 window feed a sequencer that issues one word
// per clock into a four-stage datapath: tap select, nine multipliers,
// partial sums, final sum with round and saturate into the output register.
// Throughput: one input per clock while each causes at most one word and
// out_stall is low; an input causing more words than one holds the in
// channel until its last word issues. out_stall freezes the datapath;
// in_stall holds while more than one word of the pending input is left,
// or one is left under out_stall. Reset empties the datapath, clears
// counters and window, and loads the defaults (1024 x 1024, identity).
// The user writes registers through cfg_wr_en / cfg_index / cfg_data
// only when idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module image_conv3x3_clamp_edge (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [iconv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [iconv_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [iconv_pkg::PIX_W-1:0]        pixel_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [iconv_pkg::PIX_W-1:0]             pixel_out,
	output logic [iconv_pkg::COL_W-1:0]             out_col,
	output logic [iconv_pkg::ROW_W-1:0]             out_row,
	output logic                                    last_of_run,
	output logic                                    frame_done
);

	localparam int PIX_W  = iconv_pkg::PIX_W;
	localparam int COL_W  = iconv_pkg::COL_W;
	localparam int ROW_W  = iconv_pkg::ROW_W;
	localparam int DIM_W  = iconv_pkg::DIM_W;
	localparam int TAPS   = iconv_pkg::TAPS;
	localparam int NTAP   = iconv_pkg::NTAP;
	localparam int COEF_W = iconv_pkg::COEF_W;
	localparam int PROD_W = iconv_pkg::PROD_W;
	localparam int SUM_W  = iconv_pkg::SUM_W;
	localparam int NSLOT  = iconv_pkg::NSLOT;
	localparam int FRAC   = iconv_pkg::COEF_FRAC;
	localparam int SHR_W  = SUM_W - FRAC;

	function automatic logic [1:0] sel_code(input logic use_b, input logic use_c);
		return use_c ? 2'd2 : (use_b ? 2'd1 : 2'd0);
	endfunction

	function automatic logic [PIX_W-1:0] pick3(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c, input logic [1:0] s);
		logic [PIX_W-1:0] r;
		case (s)
			2'd0: r = a;
			2'd1: r = b;
			default: r = c;
		endcase
		return r;
	endfunction

	// configuration
	logic [DIM_W-1:0]                  frame_width_q;
	logic [DIM_W-1:0]                  frame_height_q;
	logic [iconv_pkg::COEF_ROW_W-1:0]  coef_row_q [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= iconv_pkg::DIM_RESET;
			frame_height_q <= iconv_pkg::HEIGHT_RESET;
			coef_row_q[0]  <= iconv_pkg::COEF_TOP_RESET;
			coef_row_q[1]  <= iconv_pkg::COEF_MID_RESET;
			coef_row_q[2]  <= iconv_pkg::COEF_BOT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				iconv_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				iconv_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				iconv_pkg::REG_COEF_TOP:     coef_row_q[0]  <= cfg_data;
				iconv_pkg::REG_COEF_MID:     coef_row_q[1]  <= cfg_data;
				iconv_pkg::REG_COEF_BOTTOM:  coef_row_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;

	always_comb begin
		if (frame_width_q == '0)
			col_last = '0;
		else if (frame_width_q > DIM_W'(iconv_pkg::MAX_WIDTH))
			col_last = COL_W'(iconv_pkg::MAX_WIDTH - 1);
		else
			col_last = COL_W'(frame_width_q - DIM_W'(1));
		if (frame_height_q == '0)
			row_last = '0;
		else if (frame_height_q > DIM_W'(iconv_pkg::MAX_HEIGHT))
			row_last = ROW_W'(iconv_pkg::MAX_HEIGHT - 1);
		else
			row_last = ROW_W'(frame_height_q - DIM_W'(1));
	end

	// handshake and sequencing
	logic               in_accept;
	logic               adv;
	logic               out_valid_q;
	iconv_pkg::job_t    job_q;
	iconv_pkg::job_t    job_new;
	logic [NSLOT-1:0]   pick_oh;
	logic [NSLOT-1:0]   rem_left;
	logic               issue;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               is_end;
	logic               is_last;
	logic [COL_W-1:0]   col_nx;
	logic               fwd;

	assign adv      = !out_valid_q || !out_stall;
	assign pick_oh  = job_q.rem & (~job_q.rem + NSLOT'(1));
	assign rem_left = job_q.rem & ~pick_oh;
	assign issue    = (job_q.rem != '0) && adv;
	assign in_stall = !((job_q.rem == '0) || (adv && (rem_left == '0)));
	assign in_accept = in_valid && !in_stall;

	assign is_end  = col_q >= col_last;
	assign is_last = row_q >= row_last;
	assign col_nx  = is_end ? '0 : col_q + COL_W'(1);
	assign fwd     = is_end && (col_q == '0);

	always_comb begin
		job_new.rem       = {is_last && is_end, is_last && (col_q != '0),
			(row_q != '0) && is_end, (row_q != '0) && (col_q != '0)};
		job_new.col       = col_q;
		job_new.row       = row_q;
		job_new.up_edge   = row_q == ROW_W'(1);
		job_new.low_edge  = row_q == '0;
		job_new.left_edge = col_q == COL_W'(1);
		job_new.end_edge  = col_q == '0;
		job_new.frame_end = is_end && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			job_q <= job_new;
			col_q <= col_nx;
			if (is_end)
				row_q <= is_last ? '0 : row_q + ROW_W'(1);
		end else if (issue) begin
			job_q.rem <= rem_left;
		end
	end

	// line buffers, read one column ahead
	logic [PIX_W-1:0] line_above_mem [iconv_pkg::MAX_WIDTH];
	logic [PIX_W-1:0] line_cur_mem   [iconv_pkg::MAX_WIDTH];
	logic [PIX_W-1:0] rd_above_q;
	logic [PIX_W-1:0] rd_cur_q;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			line_above_mem[col_q] <= rd_cur_q;
			line_cur_mem[col_q]   <= pixel_in;
			if (fwd) begin
				rd_above_q <= rd_cur_q;
				rd_cur_q   <= pixel_in;
			end else begin
				rd_above_q <= line_above_mem[col_nx];
				rd_cur_q   <= line_cur_mem[col_nx];
			end
		end
	end

	// window
	logic [PIX_W-1:0] win_q [TAPS][TAPS];
	logic [PIX_W-1:0] new_col [TAPS];

	assign new_col[0] = (row_q >= ROW_W'(2)) ? rd_above_q : '0;
	assign new_col[1] = (row_q != '0) ? rd_cur_q : '0;
	assign new_col[2] = pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				for (int j = 0; j < TAPS; j++)
					win_q[i][j] <= '0;
		end else if (in_accept) begin
			for (int i = 0; i < TAPS; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
				win_q[i][2] <= new_col[i];
			end
		end
	end

	// tap select for the issued word
	logic              lower_sel;
	logic              end_sel;
	logic [1:0]        rs [TAPS];
	logic [1:0]        cs [TAPS];
	logic [PIX_W-1:0]  row_pick [TAPS][TAPS];
	logic [PIX_W-1:0]  tap_pix [NTAP];
	iconv_pkg::meta_t  meta_iss;

	always_comb begin
		lower_sel = pick_oh[2] || pick_oh[3];
		end_sel   = pick_oh[1] || pick_oh[3];
		rs[0] = lower_sel ? sel_code(1'b1, job_q.low_edge) : sel_code(job_q.up_edge, 1'b0);
		rs[1] = sel_code(1'b1, lower_sel);
		rs[2] = sel_code(1'b1, 1'b1);
		cs[0] = end_sel ? sel_code(1'b1, job_q.end_edge) : sel_code(job_q.left_edge, 1'b0);
		cs[1] = sel_code(1'b1, end_sel);
		cs[2] = sel_code(1'b1, 1'b1);
		for (int i = 0; i < TAPS; i++)
			for (int j = 0; j < TAPS; j++)
				row_pick[i][j] = pick3(win_q[0][j], win_q[1][j], win_q[2][j], rs[i]);
		for (int i = 0; i < TAPS; i++)
			for (int j = 0; j < TAPS; j++)
				tap_pix[i*TAPS+j] = pick3(row_pick[i][0], row_pick[i][1], row_pick[i][2],
					cs[j]);
		meta_iss.col  = end_sel ? job_q.col : job_q.col - COL_W'(1);
		meta_iss.row  = lower_sel ? job_q.row : job_q.row - ROW_W'(1);
		meta_iss.last = rem_left == '0;
		meta_iss.done = (rem_left == '0) && job_q.frame_end;
	end

	logic signed [COEF_W-1:0] coef_tap [NTAP];

	always_comb begin
		for (int i = 0; i < TAPS; i++)
			for (int j = 0; j < TAPS; j++)
				coef_tap[i*TAPS+j] = coef_row_q[i][j*COEF_W +: COEF_W];
	end

	// datapath stages
	logic                     v_s1, v_s2, v_s3;
	logic [PIX_W-1:0]         pix_s1 [NTAP];
	logic signed [PROD_W-1:0] prod_s2 [NTAP];
	logic signed [SUM_W-1:0]  psum_s3 [TAPS];
	iconv_pkg::meta_t         meta_s1, meta_s2, meta_s3;
	logic [PIX_W-1:0]         pixel_out_q;
	iconv_pkg::meta_t         meta_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= job_q.rem != '0;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	logic signed [SUM_W-1:0] total;
	logic [SHR_W-1:0]        shifted;
	logic [PIX_W-1:0]        pix_final;

	always_comb begin
		total   = psum_s3[0] + psum_s3[1] + psum_s3[2] + $signed(iconv_pkg::ROUND_HALF);
		shifted = SHR_W'(total >>> FRAC);
		if (total[SUM_W-1])
			pix_final = '0;
		else if (shifted[SHR_W-1:PIX_W] != '0)
			pix_final = iconv_pkg::PIX_MAX;
		else
			pix_final = shifted[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= tap_pix;
			meta_s1 <= meta_iss;
			for (int k = 0; k < NTAP; k++)
				prod_s2[k] <= $signed({1'b0, pix_s1[k]}) * coef_tap[k];
			meta_s2 <= meta_s1;
			for (int g = 0; g < TAPS; g++)
				psum_s3[g] <= SUM_W'(prod_s2[g*TAPS]) + SUM_W'(prod_s2[g*TAPS+1])
					+ SUM_W'(prod_s2[g*TAPS+2]);
			meta_s3     <= meta_s2;
			pixel_out_q <= pix_final;
			meta_out_q  <= meta_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign out_col     = meta_out_q.col;
	assign out_row     = meta_out_q.row;
	assign last_of_run = meta_out_q.last;
	assign frame_done  = meta_out_q.done;

	// checks
	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> ((job_q.rem & ~$past(job_q.rem)) == '0))
		else $error("pending word set grew without a new input");

	a_last_tagged: assert property (@(posedge clk) disable iff (!arst_n)
		issue && (rem_left == '0) |=> v_s1 && meta_s1.last)
		else $error("final word of an input not tagged");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && fwd |=> rd_cur_q == $past(pixel_in))
		else $error("single-column line buffer bypass lost the pixel");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame end word without last_of_run");

endmodule
`default_nettype wire
